FILE: design/eased_rect_interpolator_top_defines.svh
`ifndef EASED_RECT_INTERPOLATOR_TOP_DEFINES_SVH
`define EASED_RECT_INTERPOLATOR_TOP_DEFINES_SVH

// check a property while out of reset
`define ERI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// check a property at every edge, reset included
`define ERI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: design/erint_pkg.sv
`timescale 1ns / 1ps
package erint_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 16;
    localparam int TIME_BITS  = 24;
    localparam int DEPTH      = 256;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int DIV_STAGES = FRAC_BITS;
    localparam int E_BITS     = FRAC_BITS + 3;

    localparam longint Q30         = 64'sd1 << 30;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint LN2_Q30     = 64'sd744261118;

    typedef enum logic [2:0] {
        FN_LINEAR  = 3'd0,
        FN_IN      = 3'd1,
        FN_OUT     = 3'd2,
        FN_INOUT   = 3'd3,
        FN_OUTQUAD = 3'd4,
        FN_CUBIC   = 3'd5,
        FN_BOUNCE  = 3'd6,
        FN_ELASTIC = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0]                   func;
        logic [TIME_BITS-1:0]         elapsed_time;
        logic [TIME_BITS-1:0]         duration;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0]        start_w;
        logic [COORD_BITS-1:0]        start_h;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic [COORD_BITS-1:0]        end_w;
        logic [COORD_BITS-1:0]        end_h;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic [COORD_BITS-1:0]        cur_w;
        logic [COORD_BITS-1:0]        cur_h;
        logic                         done_res;
    } t_out_item;

    typedef logic signed [FRAC_BITS+1:0] t_sin_tbl [DEPTH];
    typedef logic [FRAC_BITS:0]          t_exp_tbl [DEPTH];

    function automatic longint q30_to_q(longint v);
        return (v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic t_sin_tbl build_sin();
        t_sin_tbl tbl;
        longint   th, x2, a, r;
        logic     neg;
        for (int j = 0; j < DEPTH; j++) begin
            th  = (longint'(j) * TWO_PI_Q30) / DEPTH;
            neg = 1'b0;
            if (th >= PI_Q30) begin
                th  = th - PI_Q30;
                neg = 1'b1;
            end
            if (th > HALF_PI_Q30) th = PI_Q30 - th;
            x2 = (th * th) >>> 30;
            a  = Q30 - x2 / 156;
            a  = Q30 - ((x2 * a) >>> 30) / 110;
            a  = Q30 - ((x2 * a) >>> 30) / 72;
            a  = Q30 - ((x2 * a) >>> 30) / 42;
            a  = Q30 - ((x2 * a) >>> 30) / 20;
            a  = Q30 - ((x2 * a) >>> 30) / 6;
            r  = q30_to_q((th * a) >>> 30);
            tbl[j] = (FRAC_BITS+2)'(neg ? -r : r);
        end
        return tbl;
    endfunction

    function automatic t_exp_tbl build_exp();
        t_exp_tbl tbl;
        longint   y, a;
        for (int j = 0; j < DEPTH; j++) begin
            y = (longint'(j) * LN2_Q30) / DEPTH;
            a = Q30;
            a = Q30 - ((y * a) >>> 30) / 12;
            a = Q30 - ((y * a) >>> 30) / 11;
            a = Q30 - ((y * a) >>> 30) / 10;
            a = Q30 - ((y * a) >>> 30) / 9;
            a = Q30 - ((y * a) >>> 30) / 8;
            a = Q30 - ((y * a) >>> 30) / 7;
            a = Q30 - ((y * a) >>> 30) / 6;
            a = Q30 - ((y * a) >>> 30) / 5;
            a = Q30 - ((y * a) >>> 30) / 4;
            a = Q30 - ((y * a) >>> 30) / 3;
            a = Q30 - ((y * a) >>> 30) / 2;
            a = Q30 - ((y * a) >>> 30);
            tbl[j] = (FRAC_BITS+1)'(q30_to_q(a));
        end
        return tbl;
    endfunction

    localparam t_sin_tbl SIN_TBL = build_sin();
    localparam t_exp_tbl EXP_TBL = build_exp();

endpackage

FILE: design/eased_rect_interpolator_top.sv
`timescale 1ns / 1ps
// Eased rectangle interpolator: one animation step per input transfer.
// Input channel i_valid / o_ready / i_data carries the easing curve, elapsed
// time, duration and the start and end rectangles. Output channel
// o_valid / i_ready / o_data returns the current rectangle and a done flag.
// From input transfer to output valid an item passes through the pipelined
// restoring divider that forms progress, the easing stage, the four
// interpolation lanes and the output register.
// Throughput is one item per cycle; a new item enters every cycle that the
// pipeline advances.
// When elapsed time reaches the duration the end rectangle is returned
// unchanged with done_res set.
// Reset clears all valid flags; no item is in flight afterward.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_ready drops until that result transfers.
module eased_rect_interpolator_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  erint_pkg::t_in_item   i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output erint_pkg::t_out_item  o_data
);
    import erint_pkg::*;

    localparam int LAT = DIV_STAGES + 5;
    localparam int DLY = LAT - 1;

    typedef struct packed {
        t_in_item item;
        logic     done;
    } t_dly;

    logic [LAT-1:0] r_vld;
    t_dly           r_dly [DLY];
    t_out_item      r_out, n_out;
    logic           s_adv;
    logic [FRAC_BITS-1:0] s_t;
    logic signed [E_BITS-1:0] s_e;
    logic [COORD_BITS-1:0] s_x, s_y, s_w, s_h;
    t_dly           s_tap_l, s_tap_o;

    assign s_adv   = !r_vld[LAT-1] || i_ready;
    assign o_ready = s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_dly[0] <= '{item: i_data, done: i_data.elapsed_time >= i_data.duration};
            for (int k = 1; k < DLY; k++) r_dly[k] <= r_dly[k-1];
            r_out <= n_out;
        end
    end

    erint_div u_div (
        .i_clk (i_clk),
        .i_en  (s_adv),
        .i_el  (i_data.elapsed_time),
        .i_du  (i_data.duration),
        .o_t   (s_t)
    );

    erint_ease u_ease (
        .i_clk  (i_clk),
        .i_en   (s_adv),
        .i_func (r_dly[DIV_STAGES-1].item.func),
        .i_t    (s_t),
        .o_e    (s_e)
    );

    assign s_tap_l = r_dly[DLY-2];
    assign s_tap_o = r_dly[DLY-1];

    erint_lane u_lane_x (
        .i_clk (i_clk), .i_en (s_adv), .i_is_signed (1'b1),
        .i_start ({s_tap_l.item.start_x[COORD_BITS-1], s_tap_l.item.start_x}),
        .i_end   ({s_tap_l.item.end_x[COORD_BITS-1], s_tap_l.item.end_x}),
        .i_e (s_e), .o_val (s_x)
    );

    erint_lane u_lane_y (
        .i_clk (i_clk), .i_en (s_adv), .i_is_signed (1'b1),
        .i_start ({s_tap_l.item.start_y[COORD_BITS-1], s_tap_l.item.start_y}),
        .i_end   ({s_tap_l.item.end_y[COORD_BITS-1], s_tap_l.item.end_y}),
        .i_e (s_e), .o_val (s_y)
    );

    erint_lane u_lane_w (
        .i_clk (i_clk), .i_en (s_adv), .i_is_signed (1'b0),
        .i_start ({1'b0, s_tap_l.item.start_w}),
        .i_end   ({1'b0, s_tap_l.item.end_w}),
        .i_e (s_e), .o_val (s_w)
    );

    erint_lane u_lane_h (
        .i_clk (i_clk), .i_en (s_adv), .i_is_signed (1'b0),
        .i_start ({1'b0, s_tap_l.item.start_h}),
        .i_end   ({1'b0, s_tap_l.item.end_h}),
        .i_e (s_e), .o_val (s_h)
    );

    always_comb begin
        if (s_tap_o.done) begin
            n_out.cur_x    = s_tap_o.item.end_x;
            n_out.cur_y    = s_tap_o.item.end_y;
            n_out.cur_w    = s_tap_o.item.end_w;
            n_out.cur_h    = s_tap_o.item.end_h;
            n_out.done_res = 1'b1;
        end else begin
            n_out.cur_x    = s_x;
            n_out.cur_y    = s_y;
            n_out.cur_w    = s_w;
            n_out.cur_h    = s_h;
            n_out.done_res = 1'b0;
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_data  = r_out;
endmodule

FILE: design/erint_div.sv
`timescale 1ns / 1ps
module erint_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [erint_pkg::TIME_BITS-1:0] i_el,
    input  logic [erint_pkg::TIME_BITS-1:0] i_du,
    output logic [erint_pkg::FRAC_BITS-1:0] o_t
);
    import erint_pkg::*;

    logic [TIME_BITS-1:0] r_rem [DIV_STAGES];
    logic [TIME_BITS-1:0] r_du  [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_q   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [TIME_BITS-1:0] p_rem, p_du, n_rem;
        logic [FRAC_BITS-1:0] p_q;
        logic [TIME_BITS:0]   sh;
        logic                 ge;
        if (k == 0) begin : g_first
            assign p_rem = i_el;
            assign p_du  = i_du;
            assign p_q   = '0;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_du  = r_du[k-1];
            assign p_q   = r_q[k-1];
        end
        assign sh    = {p_rem, 1'b0};
        assign ge    = sh >= {1'b0, p_du};
        assign n_rem = ge ? TIME_BITS'(sh - {1'b0, p_du}) : TIME_BITS'(sh);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_du[k]  <= p_du;
                r_q[k]   <= {p_q[FRAC_BITS-2:0], ge};
            end
        end
    end

    assign o_t = r_q[DIV_STAGES-1];
endmodule

FILE: design/erint_ease.sv
`timescale 1ns / 1ps
module erint_ease (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [2:0]                        i_func,
    input  logic [erint_pkg::FRAC_BITS-1:0]   i_t,
    output logic signed [erint_pkg::E_BITS-1:0] o_e
);
    import erint_pkg::*;

    localparam int  MW  = 22;
    localparam int  PW  = 2 * MW;
    localparam int  ONE = 1 << FRAC_BITS;

    logic signed [MW-1:0]  s1_a, s1_b;
    logic [FRAC_BITS+1:0]  s1_u1, s1_u2, s1_v;
    logic [FRAC_BITS+4:0]  s1_t11;
    logic signed [MW-1:0]  s1_d;
    logic [4:0]            s1_k;
    logic [5:0]            s1_c;
    logic [FRAC_BITS+3:0]  s1_e10;
    logic [3:0]            s1_sh;
    logic [IDX_BITS-1:0]   s1_eidx, s1_sidx;
    logic [FRAC_BITS:0]    s1_ev;
    logic [FRAC_BITS+5:0]  s1_x, s1_ph;
    logic [19:0]           s1_prod3;
    logic signed [FRAC_BITS+1:0] s1_sv;
    logic [FRAC_BITS:0]    s1_mag;
    logic                  s1_half;

    logic signed [PW-1:0]  r1_m;
    logic [FRAC_BITS+1:0]  r1_v;
    logic [FRAC_BITS-1:0]  r1_t;
    logic [2:0]            r1_func;
    logic                  r1_half, r1_neg, r1_zero;
    logic [5:0]            r1_c;

    logic [PW-1:0]         r2_m1, r2_m2;
    logic [FRAC_BITS-1:0]  r2_t;
    logic [2:0]            r2_func;
    logic                  r2_half, r2_neg, r2_zero;
    logic [5:0]            r2_c;

    logic [19:0]           s2_sq;
    logic [PW-1:0]         s2_m2;
    logic [19:0]           s3_p, s3_cube;
    logic signed [E_BITS:0] s3_e;
    logic signed [E_BITS-1:0] r3_e;

    always_comb begin
        s1_half = !i_t[FRAC_BITS-1];
        s1_u1   = (FRAC_BITS+2)'(ONE) - {2'b0, i_t};
        s1_u2   = (FRAC_BITS+2)'(2 * ONE) - {1'b0, i_t, 1'b0};
        s1_v    = s1_half ? {2'b0, i_t} : s1_u2;
        s1_t11  = (FRAC_BITS+5)'(i_t) * (FRAC_BITS+5)'(11);
        priority if (s1_t11 < (FRAC_BITS+5)'(4 * ONE)) begin
            s1_k = 5'd0;  s1_c = 6'd0;
        end else if (s1_t11 < (FRAC_BITS+5)'(8 * ONE)) begin
            s1_k = 5'd12; s1_c = 6'd48;
        end else if (s1_t11 < (FRAC_BITS+5)'(10 * ONE)) begin
            s1_k = 5'd18; s1_c = 6'd60;
        end else begin
            s1_k = 5'd21; s1_c = 6'd63;
        end
        s1_d = $signed(MW'({s1_t11, 1'b0})) - $signed(MW'({s1_k, {FRAC_BITS{1'b0}}}));

        s1_e10  = (FRAC_BITS+4)'(i_t) * (FRAC_BITS+4)'(10);
        s1_sh   = s1_e10[FRAC_BITS+3:FRAC_BITS];
        s1_eidx = s1_e10[FRAC_BITS-1:FRAC_BITS-IDX_BITS];
        s1_ev   = EXP_TBL[s1_eidx] >> s1_sh;
        s1_x    = (FRAC_BITS+6)'(i_t) * (FRAC_BITS+6)'(40) + (FRAC_BITS+6)'(9 * ONE);
        priority if (s1_x >= (FRAC_BITS+6)'(48 * ONE)) s1_ph = s1_x - (FRAC_BITS+6)'(48 * ONE);
        else if (s1_x >= (FRAC_BITS+6)'(36 * ONE)) s1_ph = s1_x - (FRAC_BITS+6)'(36 * ONE);
        else if (s1_x >= (FRAC_BITS+6)'(24 * ONE)) s1_ph = s1_x - (FRAC_BITS+6)'(24 * ONE);
        else if (s1_x >= (FRAC_BITS+6)'(12 * ONE)) s1_ph = s1_x - (FRAC_BITS+6)'(12 * ONE);
        else s1_ph = s1_x;
        s1_prod3 = 20'(s1_ph >> (FRAC_BITS + 2 - IDX_BITS)) * 20'd683;
        s1_sidx  = IDX_BITS'(s1_prod3 >> 11);
        s1_sv    = SIN_TBL[s1_sidx];
        s1_mag   = s1_sv < 0 ? (FRAC_BITS+1)'(-s1_sv) : (FRAC_BITS+1)'(s1_sv);

        unique case (t_func'(i_func))
            FN_IN: begin
                s1_a = MW'(i_t); s1_b = MW'(i_t);
            end
            FN_OUT, FN_OUTQUAD: begin
                s1_a = MW'(s1_u1); s1_b = MW'(s1_u1);
            end
            FN_INOUT, FN_CUBIC: begin
                s1_a = MW'(s1_v); s1_b = MW'(s1_v);
            end
            FN_BOUNCE: begin
                s1_a = s1_d; s1_b = s1_d;
            end
            FN_ELASTIC: begin
                s1_a = MW'(s1_ev); s1_b = MW'(s1_mag);
            end
            default: begin
                s1_a = '0; s1_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m    <= s1_a * s1_b;
            r1_v    <= s1_v;
            r1_t    <= i_t;
            r1_func <= i_func;
            r1_half <= s1_half;
            r1_neg  <= s1_sv < 0;
            r1_zero <= i_t == '0;
            r1_c    <= s1_c;
        end
    end

    always_comb begin
        s2_sq = 20'($unsigned(r1_m) >> FRAC_BITS);
        s2_m2 = PW'(s2_sq) * PW'(r1_v);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_m1   <= $unsigned(r1_m);
            r2_m2   <= s2_m2;
            r2_t    <= r1_t;
            r2_func <= r1_func;
            r2_half <= r1_half;
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
            r2_c    <= r1_c;
        end
    end

    always_comb begin
        s3_p    = 20'(r2_m1 >> FRAC_BITS);
        s3_cube = 20'(r2_m2 >> FRAC_BITS);
        unique case (t_func'(r2_func))
            FN_IN:   s3_e = (E_BITS+1)'(s3_p);
            FN_OUT, FN_OUTQUAD:
                     s3_e = (E_BITS+1)'(ONE) - (E_BITS+1)'(s3_p);
            FN_INOUT:
                if (r2_half) s3_e = (E_BITS+1)'(r2_m1 >> (FRAC_BITS - 1));
                else s3_e = (E_BITS+1)'(ONE) - (E_BITS+1)'(r2_m1 >> (FRAC_BITS + 1));
            FN_CUBIC:
                if (r2_half) s3_e = (E_BITS+1)'({s3_cube, 2'b00});
                else s3_e = (E_BITS+1)'(ONE) - (E_BITS+1)'(s3_cube >> 1);
            FN_BOUNCE:
                s3_e = (E_BITS+1)'(r2_m1 >> (FRAC_BITS + 6))
                     + (E_BITS+1)'({r2_c, {(FRAC_BITS-6){1'b0}}});
            FN_ELASTIC:
                if (r2_zero) s3_e = '0;
                else if (r2_neg) s3_e = (E_BITS+1)'(ONE) - (E_BITS+1)'(s3_p);
                else s3_e = (E_BITS+1)'(ONE) + (E_BITS+1)'(s3_p);
            default: s3_e = (E_BITS+1)'(r2_t);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r3_e <= E_BITS'(s3_e);
    end

    assign o_e = r3_e;
endmodule

FILE: design/erint_lane.sv
`timescale 1ns / 1ps
module erint_lane (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic                                 i_is_signed,
    input  logic signed [erint_pkg::COORD_BITS:0] i_start,
    input  logic signed [erint_pkg::COORD_BITS:0] i_end,
    input  logic signed [erint_pkg::E_BITS-1:0]  i_e,
    output logic [erint_pkg::COORD_BITS-1:0]     o_val
);
    import erint_pkg::*;

    localparam int DW = COORD_BITS + 2;
    localparam int PW = DW + E_BITS;
    localparam int RW = PW - FRAC_BITS + 1;

    logic signed [DW-1:0] s_diff;
    logic signed [PW-1:0] r_p;
    logic signed [COORD_BITS:0] r_s;
    logic                 r_sgn;
    logic [PW-1:0]        s_mag;
    logic signed [RW-1:0] s_q, s_r, s_hi, s_lo;

    assign s_diff = DW'(i_end) - DW'(i_start);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= PW'(s_diff) * PW'(i_e);
            r_s   <= i_start;
            r_sgn <= i_is_signed;
        end
    end

    always_comb begin
        s_mag = r_p < 0 ? PW'(-r_p) : PW'(r_p);
        s_q   = RW'((s_mag + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        s_r   = r_p < 0 ? RW'(r_s) - s_q : RW'(r_s) + s_q;
        if (r_sgn) begin
            s_hi = RW'((1 << (COORD_BITS - 1)) - 1);
            s_lo = -RW'(1 << (COORD_BITS - 1));
        end else begin
            s_hi = RW'((64'd1 << COORD_BITS) - 1);
            s_lo = '0;
        end
        priority if (s_r < s_lo) o_val = COORD_BITS'(s_lo);
        else if (s_r > s_hi) o_val = COORD_BITS'(s_hi);
        else o_val = COORD_BITS'(s_r);
    end
endmodule

FILE: design/erint_checker.sv
`timescale 1ns / 1ps
`include "eased_rect_interpolator_top_defines.svh"
module erint_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input erint_pkg::t_out_item o_data
);
    import erint_pkg::*;

    `ERI_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)
    `ERI_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready)
    `ERI_ASSERT(a_ready_follows_sink, i_clk, i_rst_n, o_ready == (!o_valid || i_ready))
    `ERI_ASSERT(a_stall_holds, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_data))
endmodule

bind eased_rect_interpolator_top erint_checker u_erint_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
